FILE: src/cdhp_pkg.sv
// Types, codes and constants of the cut detector with heartbeat PWM.
// Used by the channel interfaces and the top level; depends on nothing.
package cdhp_pkg;

   localparam int SAMPLE_W       = 10;
   localparam int THRESHOLD_W    = 10;
   localparam int PERIOD_W       = 16;
   localparam int PHASE_W        = 16;
   localparam int DUTY_W         = 8;
   localparam int MASK_W         = 5;
   localparam int SAMPLE_INPUTS  = 5;
   localparam int OPCODE_W       = 2;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 16;
   localparam int STORED_ENTRIES = 68;
   localparam int TBL_IDX_W      = $clog2(STORED_ENTRIES);
   localparam int START_COUNT    = 4;
   localparam int COUNT_W        = $clog2(SAMPLE_INPUTS + 1);

   localparam logic [DUTY_W-1:0]      BASE_LEVEL    = 8'd31;
   localparam logic [DUTY_W-1:0]      DUTY_OFF      = 8'd0;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 10'd512;
   localparam logic [PERIOD_W-1:0]    PERIOD_RST    = 16'd932;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK  = 2'd0,
      OP_STOP  = 2'd1,
      OP_START = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CUT_THRESHOLD = 1'b0,
      CSR_PULSE_PERIOD  = 1'b1
   } csr_index_type;

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]               opcode;
      sample_type [SAMPLE_INPUTS-1:0]    samples;
   } req_beat_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              heater_on;
      logic [MASK_W-1:0] cut_mask;
      logic              pulse_active;
   } rsp_beat_type;

   localparam logic [DUTY_W-1:0] BEAT_TABLE [STORED_ENTRIES] = '{
      8'h2a, 8'h29, 8'h28, 8'h27, 8'h26, 8'h25, 8'h24, 8'h23,
      8'h22, 8'h21, 8'h20, 8'h1f, 8'h28, 8'h33, 8'h3e, 8'h49,
      8'h54, 8'h5f, 8'h6a, 8'h76, 8'h81, 8'h8c, 8'h97, 8'ha2,
      8'had, 8'hb8, 8'hc3, 8'hcf, 8'hda, 8'he5, 8'hf0, 8'hfb,
      8'hf9, 8'hef, 8'he5, 8'hdb, 8'hd1, 8'hc7, 8'hbe, 8'hb4,
      8'haa, 8'ha0, 8'h96, 8'h8c, 8'h83, 8'h79, 8'h6f, 8'h65,
      8'h5b, 8'h52, 8'h48, 8'h3e, 8'h34, 8'h2a, 8'h20, 8'h20,
      8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
      8'h29, 8'h2b, 8'h2c, 8'h2d
   };

endpackage

FILE: src/cdhp_intf.sv
// Valid/ready channel interfaces for tick requests and result beats.
// Depends on cdhp_pkg for field widths.
interface cdhp_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [cdhp_pkg::OPCODE_W-1:0]           opcode;
   logic [cdhp_pkg::SAMPLE_W-1:0]           sample_one;
   logic [cdhp_pkg::SAMPLE_W-1:0]           sample_two;
   logic [cdhp_pkg::SAMPLE_W-1:0]           sample_three;
   logic [cdhp_pkg::SAMPLE_W-1:0]           sample_four;
   logic [cdhp_pkg::SAMPLE_W-1:0]           sample_five;

   modport source (output valid, opcode, sample_one, sample_two, sample_three,
                   sample_four, sample_five, input ready);
   modport sink   (input valid, opcode, sample_one, sample_two, sample_three,
                   sample_four, sample_five, output ready);
endinterface

interface cdhp_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [cdhp_pkg::DUTY_W-1:0]             duty;
   logic                                    heater_on;
   logic [cdhp_pkg::MASK_W-1:0]             cut_mask;
   logic                                    pulse_active;

   modport source (output valid, duty, heater_on, cut_mask, pulse_active, input ready);
   modport sink   (input valid, duty, heater_on, cut_mask, pulse_active, output ready);
endinterface

FILE: src/cut_detect_heartbeat_pwm.sv
// Top level of the cut detector with latched heater and heartbeat PWM.
// Depends on cdhp_pkg and the channel interfaces in cdhp_intf.sv.
//
//   channel   dir   handshake      beat
//   req_ch    in    valid/ready    opcode, sample_one .. sample_five
//   rsp_ch    out   valid/ready    duty, heater_on, cut_mask, pulse_active
//   csr_*     in    csr_wr_en      csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_ch is ready; a request passes the input register,
// then the result register.
// State update and result forming sit in one combinational pass after the input register.
// Synchronous active-high reset clears flags, heater, pulse, phase and both valids.
// A stalled result holds; the input register still takes one more beat behind it.
module cut_detect_heartbeat_pwm #(
   parameter int TABLE_LEN = 68,
   parameter int CHANNELS  = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [cdhp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cdhp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   cdhp_req_if.sink                             req_ch,
   cdhp_rsp_if.source                           rsp_ch
);

   localparam logic [cdhp_pkg::PHASE_W:0] TableLenW = (cdhp_pkg::PHASE_W + 1)'(TABLE_LEN);

   logic [cdhp_pkg::THRESHOLD_W-1:0] threshold_ff;
   logic [cdhp_pkg::PERIOD_W-1:0]    period_ff;

   logic                             in_valid_ff;
   cdhp_pkg::req_beat_type           in_beat_ff;
   logic                             out_valid_ff;
   cdhp_pkg::rsp_beat_type           out_beat_ff;

   logic [cdhp_pkg::MASK_W-1:0]      flags_ff, flags_in;
   logic                             heater_ff, heater_in;
   logic                             run_ff, run_in;
   logic [cdhp_pkg::PHASE_W-1:0]     phase_ff, phase_in;

   logic                             advance;
   logic                             fire;
   logic [cdhp_pkg::MASK_W-1:0]      hit;
   logic [cdhp_pkg::COUNT_W-1:0]     flag_cnt;
   logic [cdhp_pkg::PHASE_W-1:0]     phase_cur;
   logic [cdhp_pkg::PHASE_W:0]       phase_next;
   logic [cdhp_pkg::PHASE_W:0]       period_eff;
   logic [cdhp_pkg::DUTY_W-1:0]      duty_val;
   cdhp_pkg::req_beat_type           req_beat;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   assign req_beat.opcode     = req_ch.opcode;
   assign req_beat.samples[0] = req_ch.sample_one;
   assign req_beat.samples[1] = req_ch.sample_two;
   assign req_beat.samples[2] = req_ch.sample_three;
   assign req_beat.samples[3] = req_ch.sample_four;
   assign req_beat.samples[4] = req_ch.sample_five;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= cdhp_pkg::THRESHOLD_RST;
         period_ff    <= cdhp_pkg::PERIOD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            cdhp_pkg::CSR_CUT_THRESHOLD: threshold_ff <= csr_wdata[cdhp_pkg::THRESHOLD_W-1:0];
            cdhp_pkg::CSR_PULSE_PERIOD:  period_ff    <= csr_wdata[cdhp_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      hit = '0;
      for (int i = 0; i < cdhp_pkg::SAMPLE_INPUTS; i++) begin
         if (i < CHANNELS && in_beat_ff.samples[i] < threshold_ff) begin
            hit[i] = 1'b1;
         end
      end
   end

   always_comb begin
      flags_in   = flags_ff;
      heater_in  = heater_ff;
      run_in     = run_ff;
      phase_cur  = phase_ff;
      flag_cnt   = '0;
      period_eff = ({1'b0, period_ff} > TableLenW) ? {1'b0, period_ff} : TableLenW;
      case (in_beat_ff.opcode)
         cdhp_pkg::OP_TICK: begin
            flags_in  = flags_ff | hit;
            heater_in = heater_ff | (|flags_in);
            for (int i = 0; i < cdhp_pkg::MASK_W; i++) begin
               flag_cnt = flag_cnt + cdhp_pkg::COUNT_W'(flags_in[i]);
            end
            if (flag_cnt >= cdhp_pkg::COUNT_W'(cdhp_pkg::START_COUNT) && !run_ff) begin
               run_in    = 1'b1;
               phase_cur = '0;
            end
         end
         cdhp_pkg::OP_STOP: begin
            run_in = 1'b0;
         end
         cdhp_pkg::OP_START: begin
            run_in    = 1'b1;
            phase_cur = '0;
         end
         default: ;
      endcase

      phase_next = {1'b0, phase_cur} + 1'b1;
      phase_in   = phase_cur;
      if (in_beat_ff.opcode == cdhp_pkg::OP_TICK && run_in) begin
         phase_in = (phase_next >= period_eff) ? '0 : phase_next[cdhp_pkg::PHASE_W-1:0];
      end

      if (!run_in) begin
         duty_val = cdhp_pkg::DUTY_OFF;
      end else if ({1'b0, phase_cur} < TableLenW &&
                   phase_cur < cdhp_pkg::PHASE_W'(cdhp_pkg::STORED_ENTRIES)) begin
         duty_val = cdhp_pkg::BEAT_TABLE[phase_cur[cdhp_pkg::TBL_IDX_W-1:0]];
      end else begin
         duty_val = cdhp_pkg::BASE_LEVEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         heater_ff    <= 1'b0;
         run_ff       <= 1'b0;
         phase_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            flags_ff  <= flags_in;
            heater_ff <= heater_in;
            run_ff    <= run_in;
            phase_ff  <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_beat_ff <= req_beat;
      end
      if (fire) begin
         out_beat_ff.duty         <= duty_val;
         out_beat_ff.heater_on    <= heater_in;
         out_beat_ff.cut_mask     <= flags_in;
         out_beat_ff.pulse_active <= run_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.duty         = out_beat_ff.duty;
   assign rsp_ch.heater_on    = out_beat_ff.heater_on;
   assign rsp_ch.cut_mask     = out_beat_ff.cut_mask;
   assign rsp_ch.pulse_active = out_beat_ff.pulse_active;

   a_duty_off: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_beat_ff.pulse_active |-> out_beat_ff.duty == cdhp_pkg::DUTY_OFF)
      else $error("duty nonzero while pulse is off");

   a_heater_follows_flags: assert property (@(posedge clock) disable iff (reset)
      heater_ff == (flags_ff != '0))
      else $error("heater latch out of step with cut flags");

   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (flags_ff & $past(flags_ff)) == $past(flags_ff))
      else $error("cut flag cleared");

   a_auto_start: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(run_ff) && $past(in_beat_ff.opcode) == cdhp_pkg::OP_TICK
      |-> $countones(flags_ff) >= cdhp_pkg::START_COUNT)
      else $error("pulse started on tick without enough cut flags");

   a_stall_blocks_state: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(advance) |-> $stable(phase_ff) && $stable(run_ff))
      else $error("state moved while result stalled");

endmodule

FILE: dv/cut_detect_heartbeat_pwm_test.sv
// Self-checking testbench for cut_detect_heartbeat_pwm: directed and random request beats
// under random gaps and stalls, checked against an in-bench predictor of flags and pulse.
// Depends on cdhp_pkg, cdhp_intf.sv and the top level in src.
module cut_detect_heartbeat_pwm_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_LEN  = 68;
   localparam int CHANNELS   = 5;
   localparam int IDLE_LIMIT = 5000;
   localparam int PHASE_ITEMS = 130;
   localparam logic [cdhp_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam cdhp_pkg::sample_type S_MIN = '0;
   localparam cdhp_pkg::sample_type S_MAX = '1;

   class pwm_tracker;
      logic [cdhp_pkg::THRESHOLD_W-1:0] threshold;
      logic [cdhp_pkg::PERIOD_W-1:0]    period;
      logic [cdhp_pkg::MASK_W-1:0]      flags;
      logic                             heater;
      logic                             running;
      logic [cdhp_pkg::PHASE_W-1:0]     phase;
      cdhp_pkg::rsp_beat_type           expected_q[$];
      int                               errors;

      function new();
         threshold = cdhp_pkg::THRESHOLD_RST;
         period    = cdhp_pkg::PERIOD_RST;
         flags     = '0;
         heater    = 1'b0;
         running   = 1'b0;
         phase     = '0;
         errors    = 0;
      endfunction

      function void write_reg(cdhp_pkg::csr_index_type idx,
                              logic [cdhp_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            cdhp_pkg::CSR_CUT_THRESHOLD: threshold = val[cdhp_pkg::THRESHOLD_W-1:0];
            cdhp_pkg::CSR_PULSE_PERIOD:  period = val[cdhp_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [cdhp_pkg::DUTY_W-1:0] duty_now();
         if (!running)
            return cdhp_pkg::DUTY_OFF;
         if (phase < TABLE_LEN && phase < cdhp_pkg::STORED_ENTRIES)
            return cdhp_pkg::BEAT_TABLE[phase[cdhp_pkg::TBL_IDX_W-1:0]];
         return cdhp_pkg::BASE_LEVEL;
      endfunction

      function void take_request(cdhp_pkg::req_beat_type b);
         cdhp_pkg::rsp_beat_type          r;
         logic [cdhp_pkg::PERIOD_W-1:0]   eff;
         logic [cdhp_pkg::PHASE_W:0]      nxt;
         if (b.opcode == cdhp_pkg::OP_TICK) begin
            for (int i = 0; i < cdhp_pkg::SAMPLE_INPUTS && i < CHANNELS; i++)
               if (b.samples[i] < threshold)
                  flags[i] = 1'b1;
            if (flags != '0)
               heater = 1'b1;
            if ($countones(flags) >= cdhp_pkg::START_COUNT && !running) begin
               running = 1'b1;
               phase   = '0;
            end
            r.duty = duty_now();
            if (running) begin
               eff = (period > TABLE_LEN) ? period : cdhp_pkg::PERIOD_W'(TABLE_LEN);
               nxt = {1'b0, phase} + 1'b1;
               phase = (nxt >= eff) ? '0 : nxt[cdhp_pkg::PHASE_W-1:0];
            end
         end else begin
            if (b.opcode == cdhp_pkg::OP_STOP) begin
               running = 1'b0;
            end else if (b.opcode == cdhp_pkg::OP_START) begin
               running = 1'b1;
               phase   = '0;
            end
            r.duty = duty_now();
         end
         r.heater_on    = heater;
         r.cut_mask     = flags;
         r.pulse_active = running;
         expected_q.push_back(r);
      endfunction

      function void check_result(cdhp_pkg::rsp_beat_type got);
         cdhp_pkg::rsp_beat_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: duty %0d mask %b", got.duty,
                   got.cut_mask);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, got.duty);
            errors++;
         end
         if (got.heater_on !== want.heater_on) begin
            $error("heater_on: expected %0d, got %0d", want.heater_on, got.heater_on);
            errors++;
         end
         if (got.cut_mask !== want.cut_mask) begin
            $error("cut_mask: expected %b, got %b", want.cut_mask, got.cut_mask);
            errors++;
         end
         if (got.pulse_active !== want.pulse_active) begin
            $error("pulse_active: expected %0d, got %0d", want.pulse_active, got.pulse_active);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_wr_en;
   logic [cdhp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cdhp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   cdhp_req_if req_ch();
   cdhp_rsp_if rsp_ch();

   cut_detect_heartbeat_pwm #(
      .TABLE_LEN(TABLE_LEN),
      .CHANNELS (CHANNELS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   pwm_tracker tracker = new();
   bit         steady;
   int         req_count;
   int         rsp_count;
   int         settings_used;
   int         idle_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int rand_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic cdhp_pkg::req_beat_type make_beat(logic [cdhp_pkg::OPCODE_W-1:0] op,
                                                        cdhp_pkg::sample_type s1,
                                                        cdhp_pkg::sample_type s2,
                                                        cdhp_pkg::sample_type s3,
                                                        cdhp_pkg::sample_type s4,
                                                        cdhp_pkg::sample_type s5);
      cdhp_pkg::req_beat_type b;
      b.opcode     = op;
      b.samples[0] = s1;
      b.samples[1] = s2;
      b.samples[2] = s3;
      b.samples[3] = s4;
      b.samples[4] = s5;
      return b;
   endfunction

   function automatic cdhp_pkg::req_beat_type random_beat();
      cdhp_pkg::req_beat_type b;
      int                     r;
      int                     k;
      r = $urandom_range(0, 99);
      if (r < 90)
         b.opcode = cdhp_pkg::OP_TICK;
      else if (r < 93)
         b.opcode = cdhp_pkg::OP_STOP;
      else if (r < 97)
         b.opcode = cdhp_pkg::OP_START;
      else
         b.opcode = OP_UNUSED;
      for (int i = 0; i < cdhp_pkg::SAMPLE_INPUTS; i++) begin
         k = $urandom_range(0, 15);
         if (k == 0)
            b.samples[i] = S_MIN;
         else if (k == 1)
            b.samples[i] = S_MAX;
         else if (k == 2)
            b.samples[i] = cdhp_pkg::sample_type'($urandom_range(0, tracker.threshold));
         else
            b.samples[i] = cdhp_pkg::sample_type'($urandom_range(0, 1023));
      end
      return b;
   endfunction

   task automatic send_beat(cdhp_pkg::req_beat_type b);
      int gap;
      gap = rand_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= b.opcode;
      req_ch.sample_one   <= b.samples[0];
      req_ch.sample_two   <= b.samples[1];
      req_ch.sample_three <= b.samples[2];
      req_ch.sample_four  <= b.samples[3];
      req_ch.sample_five  <= b.samples[4];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_regs(logic [cdhp_pkg::CSR_DATA_W-1:0] thr,
                           logic [cdhp_pkg::CSR_DATA_W-1:0] per);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= cdhp_pkg::CSR_CUT_THRESHOLD;
      csr_wdata <= thr;
      tracker.write_reg(cdhp_pkg::CSR_CUT_THRESHOLD, thr);
      @(posedge clock);
      csr_index <= cdhp_pkg::CSR_PULSE_PERIOD;
      csr_wdata <= per;
      tracker.write_reg(cdhp_pkg::CSR_PULSE_PERIOD, per);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic random_phase(logic [cdhp_pkg::CSR_DATA_W-1:0] thr,
                               logic [cdhp_pkg::CSR_DATA_W-1:0] per, bit no_gaps);
      set_regs(thr, per);
      steady = no_gaps;
      repeat (PHASE_ITEMS) send_beat(random_beat());
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         int gap;
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         gap = rand_gap();
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result('{duty: rsp_ch.duty, heater_on: rsp_ch.heater_on,
                                   cut_mask: rsp_ch.cut_mask,
                                   pulse_active: rsp_ch.pulse_active});
            rsp_count++;
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.take_request(make_beat(req_ch.opcode, req_ch.sample_one,
                                           req_ch.sample_two, req_ch.sample_three,
                                           req_ch.sample_four, req_ch.sample_five));
            req_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("cut_detect_heartbeat_pwm_test failed");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= cdhp_pkg::OP_TICK;
      req_ch.sample_one   <= '0;
      req_ch.sample_two   <= '0;
      req_ch.sample_three <= '0;
      req_ch.sample_four  <= '0;
      req_ch.sample_five  <= '0;
      csr_wr_en           <= 1'b0;
      csr_index           <= cdhp_pkg::CSR_CUT_THRESHOLD;
      csr_wdata           <= '0;
      steady              = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_TICK, 10'd512, 10'd600, 10'd700, 10'd800, 10'd900));

      set_regs(16'd0, 16'd0);
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(OP_UNUSED, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(cdhp_pkg::OP_START, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN));
      send_beat(make_beat(OP_UNUSED, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_STOP, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(cdhp_pkg::OP_STOP, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));

      set_regs(16'd1023, 16'hffff);
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MIN, S_MIN, 10'd1022, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, 10'd1022, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_START, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
      send_beat(make_beat(cdhp_pkg::OP_STOP, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(OP_UNUSED, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
      send_beat(make_beat(cdhp_pkg::OP_TICK, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));

      random_phase(16'd1, 16'd0, 1'b0);
      random_phase(16'd1023, 16'hffff, 1'b1);
      random_phase(16'd0, 16'd68, 1'b0);
      random_phase(cdhp_pkg::CSR_DATA_W'($urandom_range(0, 1023)),
                   cdhp_pkg::CSR_DATA_W'($urandom_range(69, 200)), 1'b0);
      random_phase(16'd512, 16'd932, 1'b0);

      drain();
      repeat (8) @(posedge clock);
      if (tracker.expected_q.size() != 0) begin
         $error("%0d result beats never arrived", tracker.expected_q.size());
         tracker.errors++;
      end
      $display("Covered %0d request beats and %0d result beats over %0d register settings,",
               req_count, rsp_count, settings_used + 1);
      $display("including sticky cut flags, automatic start, period wrap and base level.");
      if (tracker.errors == 0) begin
         $display("cut_detect_heartbeat_pwm_test passed");
      end else begin
         $display("cut_detect_heartbeat_pwm_test failed");
      end
      $finish;
   end

endmodule
